// File: rtl/lpc_pkg.sv
package lpc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 10;
    localparam int ACC_W      = 36;
    localparam int OPD_W      = 18;

    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_BATCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] MODE_EMPTY     = 2'd0;
    localparam logic [1:0] MODE_SELECTING = 2'd1;
    localparam logic [1:0] MODE_READY     = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               release_req;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] count;
        logic             appended;
        logic             crossing_found;
    } out_word_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
    } mac_ctl_t;

endpackage

// File: rtl/lasso_polyline_capture.sv
// channel | dir | handshake           | word
// in      | in  | in_valid/in_stall   | in_data (opcode, point_x, point_y, release_req)
// out     | out | out_valid/out_stall | out_data (mode, count, appended, crossing_found)
// cfg     | in  | cfg_valid/cfg_ready | cfg_data (min spacing)
//
// one item at a time: a point item is appended at once on an empty store, else it
// is compared with the last stored point first; clear or unused opcode goes straight
// to the result; end of batch walks segment pairs, each with four reads on the single
// store read port and six products on the shared multiplier. in_stall is high while
// an item is in work. a held result stalls only the final hand-off. reset: empty, min
// spacing 50; the store needs no clearing pass.
module lasso_polyline_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lpc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lpc_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [11:0]         cfg_data
);
    import lpc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_PRD    = 11'b00000000010,
        S_PDIF   = 11'b00000000100,
        S_PMUL   = 11'b00000001000,
        S_PCMP   = 11'b00000010000,
        S_APPEND = 11'b00000100000,
        S_LD     = 11'b00001000000,
        S_DIF    = 11'b00010000000,
        S_MAC    = 11'b00100000000,
        S_TEST   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0]        min_reg;
    logic [1:0]         mode_reg;
    logic [CNT_W-1:0]   cnt_reg;
    in_word_t           item_reg;
    logic               app_reg, cross_reg;
    logic [2:0]         step_reg;
    logic [ADDR_W-1:0]  i_reg, j_reg;
    logic [31:0]        pt_reg [4];
    logic signed [16:0] dax_reg, day_reg, dbx_reg, dby_reg, wx_reg, wy_reg;
    logic signed [ACC_W-1:0] den_reg, tn_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic               accept, out_load;
    logic               st_wr_en, st_rd_en;
    logic [ADDR_W-1:0]  st_wr_addr, st_rd_addr;
    logic [31:0]        st_rd_data;
    mac_ctl_t           mac_ctl;
    logic signed [OPD_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] acc;
    logic               crossing;
    logic [CNT_W-1:0]   cnt_eff;
    logic [1:0]         ld_idx;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cnt_eff   = (mode_reg == MODE_READY) ? '0 : cnt_reg;
    assign ld_idx    = 2'(step_reg - 3'd1);

    function automatic logic strictly_unit(input logic signed [ACC_W-1:0] num,
                                           input logic signed [ACC_W-1:0] den);
        if (den > 0)
            return (num > 0) && (num < den);
        return (num < 0) && (num > den);
    endfunction

    // segment pair test once the last product is in
    assign crossing = (den_reg != 0) && strictly_unit(tn_reg, den_reg)
                      && strictly_unit(acc, den_reg);

    lpc_store u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data ({item_reg.point_y, item_reg.point_x}),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    lpc_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    // store port control
    always_comb
    begin
        st_wr_en   = (state_reg == S_APPEND) && (cnt_eff < CNT_W'(MAX_POINTS - 1));
        st_wr_addr = ADDR_W'(cnt_eff);
        st_rd_en   = 1'b0;
        st_rd_addr = i_reg;
        if (state_reg == S_PRD)
        begin
            st_rd_en   = 1'b1;
            st_rd_addr = ADDR_W'(cnt_reg - 1'b1);
        end
        else if (state_reg == S_LD && step_reg < 3'd4)
        begin
            st_rd_en = 1'b1;
            case (step_reg[1:0])
                2'd0:    st_rd_addr = i_reg;
                2'd1:    st_rd_addr = i_reg + 1'b1;
                2'd2:    st_rd_addr = j_reg;
                default: st_rd_addr = j_reg + 1'b1;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        if (state_reg == S_PMUL)
        begin
            mac_ctl.en = 1'b1;
            case (step_reg)
                3'd0:
                begin
                    mac_ctl.clr = 1'b1;
                    mac_a = OPD_W'(dax_reg);
                    mac_b = OPD_W'(dax_reg);
                end
                3'd1:
                begin
                    mac_a = OPD_W'(day_reg);
                    mac_b = OPD_W'(day_reg);
                end
                default:
                begin
                    mac_ctl.sub = 1'b1;
                    mac_a = $signed({6'd0, min_reg});
                    mac_b = $signed({6'd0, min_reg});
                end
            endcase
        end
        else if (state_reg == S_MAC)
        begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = !step_reg[0];
            mac_ctl.sub = step_reg[0];
            case (step_reg)
                3'd0:    begin mac_a = OPD_W'(dax_reg); mac_b = OPD_W'(dby_reg); end
                3'd1:    begin mac_a = OPD_W'(day_reg); mac_b = OPD_W'(dbx_reg); end
                3'd2:    begin mac_a = OPD_W'(wx_reg);  mac_b = OPD_W'(dby_reg); end
                3'd3:    begin mac_a = OPD_W'(wy_reg);  mac_b = OPD_W'(dbx_reg); end
                3'd4:    begin mac_a = OPD_W'(wx_reg);  mac_b = OPD_W'(day_reg); end
                default: begin mac_a = OPD_W'(wy_reg);  mac_b = OPD_W'(dax_reg); end
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == OP_POINT)
                        state_next = (cnt_reg == '0) ? S_APPEND : S_PRD;
                    else if (in_data.opcode == OP_BATCH && cnt_reg >= CNT_W'(3))
                        state_next = S_LD;
                    else
                        state_next = S_OUT;
                end
            end
            S_PRD:    state_next = S_PDIF;
            S_PDIF:   state_next = S_PMUL;
            S_PMUL:   if (step_reg == 3'd2) state_next = S_PCMP;
            S_PCMP:   state_next = (!acc[ACC_W-1] && acc != 0) ? S_APPEND : S_OUT;
            S_APPEND: state_next = S_OUT;
            S_LD:     if (step_reg == 3'd4) state_next = S_DIF;
            S_DIF:    state_next = S_MAC;
            S_MAC:    if (step_reg == 3'd5) state_next = S_TEST;
            S_TEST:
            begin
                if (crossing)
                    state_next = S_OUT;
                else if ({1'b0, j_reg} + 11'd2 < {1'b0, cnt_reg})
                    state_next = S_LD;
                else if ({1'b0, i_reg} + 11'd3 < {1'b0, cnt_reg})
                    state_next = S_LD;
                else
                    state_next = S_OUT;
            end
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= 12'd50;
            mode_reg      <= MODE_EMPTY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                min_reg <= cfg_data;
            if (state_reg != state_next)
                step_reg <= '0;
            else
                step_reg <= step_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE && accept && in_data.opcode == OP_CLEAR)
            begin
                mode_reg <= MODE_EMPTY;
                cnt_reg  <= '0;
            end
            if (state_reg == S_APPEND)
            begin
                mode_reg <= MODE_SELECTING;
                cnt_reg  <= st_wr_en ? cnt_eff + 1'b1 : cnt_eff;
            end
            if (state_reg == S_OUT && state_next == S_IDLE
                && item_reg.opcode == OP_BATCH && mode_reg == MODE_SELECTING
                && (item_reg.release_req || cross_reg))
                mode_reg <= MODE_READY;
        end
    end

    // item data path
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= in_data;
            app_reg   <= 1'b0;
            cross_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= ADDR_W'(1);
        end
        if (state_reg == S_PDIF)
        begin
            dax_reg <= {item_reg.point_x[15], item_reg.point_x}
                       - {st_rd_data[15], st_rd_data[15:0]};
            day_reg <= {item_reg.point_y[15], item_reg.point_y}
                       - {st_rd_data[31], st_rd_data[31:16]};
        end
        if (state_reg == S_APPEND)
            app_reg <= st_wr_en;
        if (state_reg == S_LD && step_reg != 3'd0)
            pt_reg[ld_idx] <= st_rd_data;
        if (state_reg == S_DIF)
        begin
            dax_reg <= {pt_reg[1][15], pt_reg[1][15:0]} - {pt_reg[0][15], pt_reg[0][15:0]};
            day_reg <= {pt_reg[1][31], pt_reg[1][31:16]} - {pt_reg[0][31], pt_reg[0][31:16]};
            dbx_reg <= {pt_reg[3][15], pt_reg[3][15:0]} - {pt_reg[2][15], pt_reg[2][15:0]};
            dby_reg <= {pt_reg[3][31], pt_reg[3][31:16]} - {pt_reg[2][31], pt_reg[2][31:16]};
            wx_reg  <= {pt_reg[2][15], pt_reg[2][15:0]} - {pt_reg[0][15], pt_reg[0][15:0]};
            wy_reg  <= {pt_reg[2][31], pt_reg[2][31:16]} - {pt_reg[0][31], pt_reg[0][31:16]};
        end
        if (state_reg == S_MAC && step_reg == 3'd2)
            den_reg <= acc;
        if (state_reg == S_MAC && step_reg == 3'd4)
            tn_reg <= acc;
        if (state_reg == S_TEST)
        begin
            if (crossing)
                cross_reg <= 1'b1;
            else if ({1'b0, j_reg} + 11'd2 < {1'b0, cnt_reg})
                j_reg <= j_reg + 1'b1;
            else
            begin
                i_reg <= i_reg + 1'b1;
                j_reg <= i_reg + ADDR_W'(2);
            end
        end
        if (out_load)
        begin
            out_reg.count          <= cnt_reg;
            out_reg.appended       <= app_reg;
            out_reg.crossing_found <= cross_reg;
            if (item_reg.opcode == OP_BATCH && mode_reg == MODE_SELECTING
                && (item_reg.release_req || cross_reg))
                out_reg.mode <= MODE_READY;
            else
                out_reg.mode <= mode_reg;
        end
    end

endmodule

// File: rtl/lpc_store.sv
module lpc_store (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [lpc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [31:0]               wr_data,
    input  logic                      rd_en,
    input  logic [lpc_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]               rd_data
);
    import lpc_pkg::*;

    logic [31:0] mem [MAX_POINTS];

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/lpc_mac.sv
module lpc_mac (
    input  logic                            clk,
    input  lpc_pkg::mac_ctl_t               ctl,
    input  logic signed [lpc_pkg::OPD_W-1:0] a,
    input  logic signed [lpc_pkg::OPD_W-1:0] b,
    output logic signed [lpc_pkg::ACC_W-1:0] acc
);
    import lpc_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // one multiply and accumulate per cycle while ctl.en is high
    always_comb
    begin
        prod     = ACC_W'(a * b);
        base     = ctl.clr ? '0 : acc_reg;
        acc_next = ctl.sub ? base - prod : base + prod;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/lpc_checker.sv
module lpc_props (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input lpc_pkg::out_word_t out_data
);
    import lpc_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

    // empty mode means an empty store
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == MODE_EMPTY |-> out_data.count == '0)
        else $error("empty mode with points held");

    // a stored point leaves the lasso selecting with points
    a_app: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.appended |->
            out_data.mode == MODE_SELECTING && out_data.count != '0)
        else $error("appended point without selecting mode");

    // one item cannot both store and find a crossing
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.appended && out_data.crossing_found))
        else $error("appended and crossing in one word");

endmodule

bind lasso_polyline_capture lpc_props u_lpc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: bench/lpc_checker.sv
module lpc_checker
    import lpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [11:0] cfg_data,
    output int          errors,
    output int          pending
);

    // shadow copy of the lasso state
    logic [11:0]        spacing;
    logic [1:0]         lasso_mode;
    int                 held;
    logic signed [15:0] store_x [MAX_POINTS];
    logic signed [15:0] store_y [MAX_POINTS];
    out_word_t          expected_q[$];

    function automatic bit strictly_between(longint num, longint den);
        if (den > 0)
            return num > 0 && num < den;
        return num < 0 && num > den;
    endfunction

    // exact segment crossing test, no division
    function automatic bit segments_cross(int i, int j);
        longint d1x, d1y, d2x, d2y, wx, wy, den;
        d1x = longint'(store_x[i+1]) - longint'(store_x[i]);
        d1y = longint'(store_y[i+1]) - longint'(store_y[i]);
        d2x = longint'(store_x[j+1]) - longint'(store_x[j]);
        d2y = longint'(store_y[j+1]) - longint'(store_y[j]);
        wx  = longint'(store_x[j]) - longint'(store_x[i]);
        wy  = longint'(store_y[j]) - longint'(store_y[i]);
        den = d1x * d2y - d1y * d2x;
        if (den == 0)
            return 1'b0;
        return strictly_between(wx * d2y - wy * d2x, den) &&
               strictly_between(wx * d1y - wy * d1x, den);
    endfunction

    function automatic bit lasso_crosses();
        for (int i = 0; i + 1 < held; i++)
            for (int j = i + 1; j + 1 < held; j++)
                if (segments_cross(i, j))
                    return 1'b1;
        return 1'b0;
    endfunction

    // next state and result word for one input word
    task automatic predict_word(input in_word_t w);
        out_word_t r;
        longint    dx, dy;
        bit        take;
        bit        finish;
        r = '0;
        case (w.opcode)
            OP_POINT:
            begin
                take = (held == 0);
                if (!take)
                begin
                    dx = longint'(w.point_x) - longint'(store_x[held-1]);
                    dy = longint'(w.point_y) - longint'(store_y[held-1]);
                    take = (dx * dx + dy * dy) > longint'(spacing) * longint'(spacing);
                end
                if (take)
                begin
                    if (lasso_mode == MODE_READY)
                        held = 0;
                    lasso_mode = MODE_SELECTING;
                    if (held < MAX_POINTS - 1)
                    begin
                        store_x[held] = w.point_x;
                        store_y[held] = w.point_y;
                        held++;
                        r.appended = 1'b1;
                    end
                end
            end
            OP_BATCH:
            begin
                finish = w.release_req;
                if (lasso_crosses())
                begin
                    r.crossing_found = 1'b1;
                    finish = 1'b1;
                end
                if (finish && lasso_mode == MODE_SELECTING)
                    lasso_mode = MODE_READY;
            end
            OP_CLEAR:
            begin
                lasso_mode = MODE_EMPTY;
                held = 0;
            end
            default:
            begin
            end
        endcase
        r.mode  = lasso_mode;
        r.count = held[CNT_W-1:0];
        expected_q.push_back(r);
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            spacing    = 12'd50;
            lasso_mode = MODE_EMPTY;
            held       = 0;
            errors     = 0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            // result word against oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %p", $time, out_data);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.mode !== want.mode || out_data.count !== want.count ||
                        out_data.appended !== want.appended ||
                        out_data.crossing_found !== want.crossing_found)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, want, out_data);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_data);
            if (cfg_valid && cfg_ready)
                spacing = cfg_data;
            pending = expected_q.size();
        end
    end

endmodule

// File: bench/tb.sv
module tb;
    import lpc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    int          errors;
    int          pending;

    int          tx_pct;
    int          rx_pct;
    int          spacing;
    int          since_clear;
    int          words_sent;
    int          hold_left;
    bit          hold_req;
    int          quiet_cycles;

    lasso_polyline_capture dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lpc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver: random stall plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout, %0d words outstanding", pending);
            $display("Verification failed");
            $finish;
        end
    end

    // offer one word, idling at random first
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic rel);
        in_word_t w;
        w.opcode      = op;
        w.point_x     = x;
        w.point_y     = y;
        w.release_req = rel;
        if (op == OP_POINT)
            since_clear++;
        if (op == OP_CLEAR)
            since_clear = 0;
        send_word(w);
    endtask

    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
        send_op(OP_POINT, x, y, 1'($urandom_range(1)));
    endtask

    task automatic send_batch(input logic rel);
        send_op(OP_BATCH, 16'($urandom), 16'($urandom), rel);
    endtask

    task automatic send_clear();
        send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    endtask

    // wait until every result word is back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_spacing(input int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v[11:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        spacing = v;
    endtask

    // two segments that cross in the middle: bowtie
    task automatic send_bowtie();
        int s;
        logic signed [15:0] bx, by;
        s  = spacing + 1 + $urandom_range(200);
        bx = 16'($urandom);
        by = 16'($urandom);
        send_point(bx, by);
        send_point(16'(bx + 2 * s), 16'(by + 2 * s));
        send_point(16'(bx + 2 * s), by);
        send_point(bx, 16'(by + 2 * s));
    endtask

    // well-formed lasso: a walk of spaced points closed by a batch word
    task automatic send_lasso();
        int n, st;
        logic signed [15:0] x, y;
        if (since_clear > 14 || $urandom_range(3) == 0)
            send_clear();
        if ($urandom_range(4) == 0)
            send_bowtie();
        else
        begin
            n = $urandom_range(2, 10);
            x = 16'($urandom);
            y = 16'($urandom);
            for (int k = 0; k < n; k++)
            begin
                send_point(x, y);
                st = spacing + 1 + $urandom_range(150);
                x  = $urandom_range(1) ? 16'(x + st) : 16'(x - st);
                y  = $urandom_range(1) ? 16'(y + $urandom_range(st))
                                       : 16'(y - $urandom_range(st));
                if ($urandom_range(5) == 0)
                    send_batch(1'b0);
            end
        end
        send_batch($urandom_range(3) != 0);
    endtask

    // noise: random words, points too close, stray batches
    task automatic send_noise();
        int r;
        r = $urandom_range(5);
        if (since_clear > 14)
            send_clear();
        else if (r == 0)
            send_op(OP_POINT, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        else if (r == 1)
            send_point(16'($urandom_range(spacing / 2)), 16'($urandom_range(spacing / 2)));
        else if (r == 2)
            send_batch(1'($urandom_range(1)));
        else if (r == 3)
            send_clear();
        else if (r == 4)
            send_op(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        else
            send_op(OP_POINT, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    endtask

    initial
    begin
        int goal;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_pct      = 0;
        rx_pct      = 0;
        spacing     = 50;
        since_clear = 0;
        words_sent  = 0;
        hold_left   = 0;
        hold_req    = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every opcode, edge geometry
        send_batch(1'b1);
        send_op(OP_UNUSED, 16'sh7fff, -16'sh8000, 1'b1);
        send_point(-16'sh8000, -16'sh8000);
        send_point(-16'sh8000 + 16'sd30, -16'sh8000 + 16'sd40);
        send_point(-16'sh8000 + 16'sd30, -16'sh8000 + 16'sd41);
        send_point(16'sh7fff, 16'sh7fff);
        send_batch(1'b0);
        send_batch(1'b1);
        send_point(16'sh7fff, -16'sh8000);
        send_clear();
        send_point(0, 0);
        send_point(200, 0);
        send_point(400, 0);
        send_point(100, 0);
        send_batch(1'b0);
        send_clear();
        send_point(0, 0);
        send_point(200, 0);
        send_point(200, 200);
        send_point(0, 0);
        send_batch(1'b0);
        send_bowtie();
        send_batch(1'b0);
        send_clear();

        // store saturation at zero spacing
        write_spacing(0);
        for (int k = 0; k < MAX_POINTS; k++)
            send_point(16'(k - 512), 16'(k));
        send_clear();

        // random phases
        for (int p = 0; p < 3; p++)
        begin
            tx_pct = (p == 0) ? 23 : (p == 1) ? 87 : 0;
            rx_pct = (p == 0) ? 87 : (p == 1) ? 23 : 0;
            write_spacing((p == 0) ? 4095 : (p == 1) ? $urandom_range(1, 300) : 50);
            send_clear();
            // long receiver hold-off while words keep coming
            if (p == 2)
                hold_req = 1'b1;
            goal = words_sent + 35;
            while (words_sent < goal)
            begin
                if ($urandom_range(4) == 0)
                    send_noise();
                else
                    send_lasso();
            end
        end
        drain();
        repeat (40) @(posedge clk);

        $display("sent %0d words over spacings 0, 50, 4095 and a random one,", words_sent);
        $display("including store saturation, crossings and a long receiver hold-off");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
